>>> design/ipv4shc_pkg.sv
// Package for the IPv4 subnet host checker: word types, parse state, character
// codes and the per-character parse functions. No dependencies.
package ipv4shc_pkg;

    localparam int unsigned CFG_INDEX_W = 2;
    localparam int unsigned CFG_DATA_W  = 8;

    localparam logic [CFG_INDEX_W-1:0] CFG_PREFIX_A = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_PREFIX_B = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_PREFIX_C = 2'd2;

    localparam logic [7:0] RST_PREFIX_A = 8'd192;
    localparam logic [7:0] RST_PREFIX_B = 8'd168;
    localparam logic [7:0] RST_PREFIX_C = 8'd4;

    localparam logic [7:0] CHAR_DOT  = 8'h2E;
    localparam logic [7:0] CHAR_ZERO = 8'h30;
    localparam logic [7:0] CHAR_NINE = 8'h39;

    localparam logic [1:0] MAX_DIGITS = 2'd3;
    localparam logic [2:0] NUM_PARTS  = 3'd4;
    localparam logic [9:0] PART_MAX   = 10'd255;
    localparam logic [7:0] OCTET_ZERO = 8'd0;
    localparam logic [7:0] OCTET_BCAST = 8'd255;

    typedef struct packed {
        logic [7:0] char_code;
        logic       char_present;
        logic       end_of_string;
    } t_in_word;

    typedef struct packed {
        logic        host_ok;
        logic [31:0] host_address;
    } t_out_word;

    typedef struct packed {
        logic [7:0] octet_a;
        logic [7:0] octet_b;
        logic [7:0] octet_c;
    } t_prefix;

    typedef struct packed {
        logic [2:0]  part_count;
        logic [1:0]  digit_count;
        logic [9:0]  part_value;
        logic [31:0] address_bits;
        logic        error_seen;
    } t_parse_state;

    localparam t_parse_state PARSE_CLEAR = '{
        part_count:   3'd0,
        digit_count:  2'd0,
        part_value:   10'd0,
        address_bits: 32'd0,
        error_seen:   1'b0
    };

    // Finish the current part: shift it into the address or flag an error.
    function automatic t_parse_state close_part(t_parse_state s);
        t_parse_state r;
        r = s;
        if (!s.error_seen) begin
            if (s.part_count >= NUM_PARTS || s.digit_count == 2'd0 ||
                s.part_value > PART_MAX) begin
                r.error_seen = 1'b1;
            end else begin
                r.address_bits = {s.address_bits[23:0], s.part_value[7:0]};
                r.part_count   = s.part_count + 3'd1;
                r.digit_count  = 2'd0;
                r.part_value   = 10'd0;
            end
        end
        return r;
    endfunction

    function automatic t_parse_state take_char(t_parse_state s, logic [7:0] c);
        t_parse_state r;
        logic [7:0]   d;
        r = s;
        d = c - CHAR_ZERO;
        if (!s.error_seen) begin
            if (c == CHAR_DOT) begin
                r = close_part(s);
            end else if (c inside {[CHAR_ZERO:CHAR_NINE]}) begin
                if (s.digit_count >= MAX_DIGITS) begin
                    r.error_seen = 1'b1;
                end else begin
                    // value * 10 + digit; at most two digits so far, so 10 bits hold it
                    r.part_value  = {s.part_value[6:0], 3'b000}
                                  + {s.part_value[8:0], 1'b0}
                                  + {6'd0, d[3:0]};
                    r.digit_count = s.digit_count + 2'd1;
                end
            end else begin
                r.error_seen = 1'b1;
            end
        end
        return r;
    endfunction

endpackage

>>> design/ipv4shc_parse.sv
// Parse state of the IPv4 subnet host checker and the one-word update logic.
// Depends on ipv4shc_pkg.
module ipv4shc_parse (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_step,
    input  ipv4shc_pkg::t_in_word i_word,
    input  ipv4shc_pkg::t_prefix  i_prefix,
    output ipv4shc_pkg::t_out_word o_result
);

    ipv4shc_pkg::t_parse_state r_state;
    ipv4shc_pkg::t_parse_state n_state;
    ipv4shc_pkg::t_parse_state s_after_char;
    ipv4shc_pkg::t_parse_state s_closed;
    logic                      s_ok;

    always_comb begin
        s_after_char = i_word.char_present
                     ? ipv4shc_pkg::take_char(r_state, i_word.char_code) : r_state;
        s_closed     = ipv4shc_pkg::close_part(s_after_char);

        s_ok = !s_closed.error_seen && s_closed.part_count == ipv4shc_pkg::NUM_PARTS
            && s_closed.address_bits[7:0] != ipv4shc_pkg::OCTET_ZERO
            && s_closed.address_bits[7:0] != ipv4shc_pkg::OCTET_BCAST
            && s_closed.address_bits[31:24] == i_prefix.octet_a
            && s_closed.address_bits[23:16] == i_prefix.octet_b
            && s_closed.address_bits[15:8] == i_prefix.octet_c;

        o_result.host_ok      = s_ok;
        o_result.host_address = s_ok ? s_closed.address_bits : 32'd0;

        // clear for the next string once the last word is taken
        n_state = i_word.end_of_string ? ipv4shc_pkg::PARSE_CLEAR : s_after_char;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ipv4shc_pkg::PARSE_CLEAR;
        end else if (i_step) begin
            r_state <= n_state;
        end
    end

    a_part_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.part_count <= ipv4shc_pkg::NUM_PARTS)
        else $error("part count above four");

    a_clear_after_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && i_word.end_of_string) |=>
        (r_state.part_count == 3'd0 && r_state.digit_count == 2'd0 && !r_state.error_seen))
        else $error("parse state not cleared after end of string");

    a_ok_matches_prefix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.host_ok |-> (o_result.host_address[31:24] == i_prefix.octet_a
            && o_result.host_address[23:16] == i_prefix.octet_b
            && o_result.host_address[15:8] == i_prefix.octet_c))
        else $error("host accepted outside the configured subnet");

endmodule

>>> design/ipv4shc_out_reg.sv
// Output register of the IPv4 subnet host checker: holds one result word until taken.
// Depends on ipv4shc_pkg.
module ipv4shc_out_reg (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_load,
    input  ipv4shc_pkg::t_out_word i_word,
    output logic                   o_full,
    output logic                   o_valid,
    input  logic                   i_ready,
    output ipv4shc_pkg::t_out_word o_word
);

    logic                   r_valid;
    ipv4shc_pkg::t_out_word r_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_word <= i_word;
        end
    end

    assign o_full  = r_valid;
    assign o_valid = r_valid;
    assign o_word  = r_word;

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> (!r_valid || i_ready))
        else $error("result word overwritten before it was taken");

    a_rejected_zero_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !r_word.host_ok) |-> r_word.host_address == 32'd0)
        else $error("rejected host carries a nonzero address");

endmodule

>>> design/ipv4_subnet_host_check_unit.sv
// IPv4 subnet host checker: one character word in per cycle, one result per string.
// Path from input accept to result valid: input register, then result register.
// Throughput: one word per cycle unless stalled; state updates once per word, single pass.
// Stall: an end-of-string word waits in the input register while the previous result is unread.
// Synchronous active-low reset clears the parse state and both valid flags and loads the
// prefix 192.168.4. Depends on ipv4shc_pkg, ipv4shc_parse and ipv4shc_out_reg.
module ipv4_subnet_host_check_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  ipv4shc_pkg::t_in_word               i_in_word,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output ipv4shc_pkg::t_out_word              o_out_word,
    input  logic                                i_cfg_we,
    input  logic [ipv4shc_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [ipv4shc_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    ipv4shc_pkg::t_prefix   r_prefix;
    logic                   r_in_valid;
    ipv4shc_pkg::t_in_word  r_in_word;
    ipv4shc_pkg::t_out_word s_result;
    logic                   s_step;
    logic                   s_out_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prefix.octet_a <= ipv4shc_pkg::RST_PREFIX_A;
            r_prefix.octet_b <= ipv4shc_pkg::RST_PREFIX_B;
            r_prefix.octet_c <= ipv4shc_pkg::RST_PREFIX_C;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                ipv4shc_pkg::CFG_PREFIX_A: r_prefix.octet_a <= i_cfg_data;
                ipv4shc_pkg::CFG_PREFIX_B: r_prefix.octet_b <= i_cfg_data;
                ipv4shc_pkg::CFG_PREFIX_C: r_prefix.octet_c <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Advance the held word unless it ends a string and the result slot is still occupied.
    assign s_step     = r_in_valid
                     && (!r_in_word.end_of_string || !s_out_full || i_out_ready);
    assign o_in_ready = !r_in_valid || s_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_word <= i_in_word;
        end
    end

    ipv4shc_parse u_parse (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (s_step),
        .i_word   (r_in_word),
        .i_prefix (r_prefix),
        .o_result (s_result)
    );

    ipv4shc_out_reg u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (s_step && r_in_word.end_of_string),
        .i_word  (s_result),
        .o_full  (s_out_full),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_word  (o_out_word)
    );

    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !s_step) |=> (r_in_valid && $stable(r_in_word)))
        else $error("stalled input word lost or changed");

    a_end_loads_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_step && r_in_word.end_of_string) |=> o_out_valid)
        else $error("end of string produced no result word");

endmodule
